// File: rtl/axrot_pkg.sv
// Shared types, constants and tables of the axis point rotator.
package axrot_pkg;

  // Sequencer states of the quaternion setup unit
  typedef enum logic [3:0] {
    S_LOAD,
    S_CORDIC,
    S_SIGN,
    S_NORM,
    S_SQUARE,
    S_ROOT,
    S_DIVIDE,
    S_MUL,
    S_RND,
    S_IDLE
  } seq_state_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ANGLE   = 3'd0,
    REG_START_X = 3'd1,
    REG_START_Y = 3'd2,
    REG_START_Z = 3'd3,
    REG_END_X   = 3'd4,
    REG_END_Y   = 3'd5,
    REG_END_Z   = 3'd6,
    REG_DIR     = 3'd7
  } cfg_reg_e;

  localparam int  CFG_IDX_W        = 3;
  localparam int  CNT_W            = 6;
  localparam int  CORDIC_STEPS_DEF = 24;
  localparam longint ANG_PI        = 64'sd3373259426;
  localparam longint ANG_HALF_PI   = 64'sd1686629713;
  localparam longint CORDIC_GAIN   = 64'sd652032874;
  localparam longint Q28_ONE       = 64'sd268435456;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_fn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/axis_rotate_points.sv
// Top level: quaternion rotation of a point stream about a configured axis.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  config    | cfg_we_i             | cfg_idx_i, cfg_data_i
//  points in | start_i & !busy_o    | atom_x_i, atom_y_i, atom_z_i, last_atom_i
//  points out| done_o (strobe)      | rot_x_o, rot_y_o, rot_z_o, last_out_o,
//            |                      | saturated_o, axis_degenerate_o
//
// One point per cycle while busy_o is low; each result passes the four register
// stages of the point datapath (two multiply banks) before it appears on done_o.
// After reset and after every config write, busy_o stays high while the setup
// unit forms the quaternion in its load, CORDIC, sign, normalize, square, root,
// divide and scale steps (the load step alone for a degenerate axis).
// The receiver cannot stall; results are shown for exactly one cycle.
module axis_rotate_points #(
  parameter int CORDIC_STEPS = axrot_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [axrot_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [31:0]                 atom_x_i,
  input  logic signed [31:0]                 atom_y_i,
  input  logic signed [31:0]                 atom_z_i,
  input  logic                               last_atom_i,
  output logic                               done_o,
  output logic signed [31:0]                 rot_x_o,
  output logic signed [31:0]                 rot_y_o,
  output logic signed [31:0]                 rot_z_o,
  output logic                               last_out_o,
  output logic                               saturated_o,
  output logic                               axis_degenerate_o
);
  import axrot_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [31:0] angle_q, ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic               dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      ax_q    <= '0;
      ay_q    <= '0;
      az_q    <= '0;
      bx_q    <= 32'sd65536;
      by_q    <= '0;
      bz_q    <= '0;
      dir_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ANGLE:   angle_q <= cfg_data_i;
        REG_START_X: ax_q    <= cfg_data_i;
        REG_START_Y: ay_q    <= cfg_data_i;
        REG_START_Z: az_q    <= cfg_data_i;
        REG_END_X:   bx_q    <= cfg_data_i;
        REG_END_Y:   by_q    <= cfg_data_i;
        REG_END_Z:   bz_q    <= cfg_data_i;
        REG_DIR:     dir_q   <= cfg_data_i[0];
      endcase
    end
  end

  logic degen;
  assign degen = (ax_q == bx_q) && (ay_q == by_q) && (az_q == bz_q);

  // ---------------- quaternion setup sequencer ----------------
  seq_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       k_q;

  logic signed [35:0] cx_q, cy_q, cz_q;
  logic               neg_q;
  logic signed [33:0] v_q [3];
  logic [32:0]        m_q;
  logic [63:0]        num_q, res_q, bit_q;
  logic [33:0]        rem_q;
  logic [31:0]        dvd_q, quo_q;
  logic signed [32:0] u_q [3];
  logic signed [68:0] mprod_q;
  logic signed [29:0] qw_q;
  logic signed [29:0] qv_q [3];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:   state_d = degen ? S_IDLE : S_CORDIC;
      S_CORDIC: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = S_SIGN;
      S_SIGN:   state_d = S_NORM;
      S_NORM:   if (m_q < 33'(64'd1 << 30) && m_q >= 33'(64'd1 << 29)) state_d = S_SQUARE;
      S_SQUARE: if (cnt_q == CNT_W'(2)) state_d = S_ROOT;
      S_ROOT:   if (bit_q == 64'd1) state_d = S_DIVIDE;
      S_DIVIDE: if (cnt_q == CNT_W'(32) && k_q == 2'd2) state_d = S_MUL;
      S_MUL:    state_d = S_RND;
      S_RND:    state_d = (k_q == 2'd2) ? S_IDLE : S_MUL;
      S_IDLE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    if (cfg_we_i) state_d = S_LOAD;
  end

  // outputs of the sequencer
  always_comb begin
    busy_o = (state_q != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else         state_q <= state_d;
  end

  // setup datapath helpers
  logic signed [35:0] h2, atan_s, tx, ty;
  logic signed [33:0] vd [3];
  logic [32:0]        va [3];
  logic [32:0]        mmax;
  logic [63:0]        sq, trial;
  logic [32:0]        a_div;
  logic [33:0]        t_div;
  logic [31:0]        q_next;
  logic signed [36:0] qr;
  logic signed [37:0] cxr;

  always_comb begin
    h2     = 36'(angle_q) <<< 1;
    atan_s = $signed(36'(atan_fn(cnt_q[4:0])));
    tx     = cx_q >>> cnt_q;
    ty     = cy_q >>> cnt_q;
    vd[0]  = 34'(bx_q) - 34'(ax_q);
    vd[1]  = 34'(by_q) - 34'(ay_q);
    vd[2]  = 34'(bz_q) - 34'(az_q);
    for (int i = 0; i < 3; i++) va[i] = vd[i][33] ? 33'(-vd[i]) : 33'(vd[i]);
    mmax = va[0];
    if (va[1] > mmax) mmax = va[1];
    if (va[2] > mmax) mmax = va[2];
    sq     = 64'(v_q[cnt_q[1:0]] * v_q[cnt_q[1:0]]);
    trial  = res_q + bit_q;
    a_div  = v_q[k_q][33] ? 33'(-v_q[k_q]) : 33'(v_q[k_q]);
    t_div  = {rem_q[32:0], dvd_q[31]};
    q_next = {quo_q[30:0], (t_div >= 34'(res_q))};
    qr     = 37'((mprod_q + 69'sd2147483648) >>> 32);
    cxr    = 38'((38'(cx_q) + 38'sd2) >>> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      unique case (state_q)
        S_LOAD:   cnt_q <= '0;
        S_CORDIC: cnt_q <= cnt_q + CNT_W'(1);
        S_NORM:   cnt_q <= '0;
        S_SQUARE: cnt_q <= cnt_q + CNT_W'(1);
        S_ROOT: begin
          cnt_q <= '0;
          k_q   <= '0;
        end
        S_DIVIDE: begin
          if (cnt_q == CNT_W'(32)) begin
            cnt_q <= '0;
            k_q   <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_RND:   k_q <= k_q + 2'd1;
        default: ;
      endcase
    end
  end

  // setup arithmetic, one step per cycle
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_LOAD: begin
        cx_q <= 36'(CORDIC_GAIN);
        cy_q <= '0;
        if (h2 > 36'(ANG_HALF_PI)) begin
          cz_q <= h2 - 36'(ANG_PI);
          neg_q <= 1'b1;
        end else if (h2 < -36'(ANG_HALF_PI)) begin
          cz_q <= h2 + 36'(ANG_PI);
          neg_q <= 1'b1;
        end else begin
          cz_q <= h2;
          neg_q <= 1'b0;
        end
        for (int i = 0; i < 3; i++) v_q[i] <= vd[i];
        m_q <= mmax;
      end
      S_CORDIC: begin
        if (!cz_q[35]) begin
          cx_q <= cx_q - ty;
          cy_q <= cy_q + tx;
          cz_q <= cz_q - atan_s;
        end else begin
          cx_q <= cx_q + ty;
          cy_q <= cy_q - tx;
          cz_q <= cz_q + atan_s;
        end
      end
      S_SIGN: begin
        if (neg_q) begin
          cx_q <= -cx_q;
          cy_q <= -cy_q;
        end
        num_q <= '0;
      end
      S_NORM: begin
        if (m_q >= 33'(64'd1 << 30)) begin
          for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] >>> 1;
          m_q <= m_q >> 1;
        end else if (m_q < 33'(64'd1 << 29)) begin
          for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
          m_q <= m_q << 1;
        end
        num_q <= '0;
      end
      S_SQUARE: begin
        num_q <= num_q + sq;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      S_ROOT: begin
        if (num_q >= trial) begin
          num_q <= num_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIVIDE: begin
        if (cnt_q == '0) begin
          rem_q <= 34'(a_div >> 2);
          dvd_q <= {a_div[1:0], 30'd0};
          quo_q <= '0;
        end else begin
          rem_q <= (t_div >= 34'(res_q)) ? t_div - 34'(res_q) : t_div;
          dvd_q <= dvd_q << 1;
          quo_q <= q_next;
          if (cnt_q == CNT_W'(32))
            u_q[k_q] <= v_q[k_q][33] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
        end
      end
      S_MUL: mprod_q <= 69'(cy_q) * 69'(u_q[k_q]);
      S_RND: begin
        if (qr > 37'(Q28_ONE))
          qv_q[k_q] <= dir_q ? -30'(Q28_ONE) : 30'(Q28_ONE);
        else if (qr < -37'(Q28_ONE))
          qv_q[k_q] <= dir_q ? 30'(Q28_ONE) : -30'(Q28_ONE);
        else
          qv_q[k_q] <= dir_q ? -30'(qr) : 30'(qr);
        if (cxr > 38'(Q28_ONE))       qw_q <= 30'(Q28_ONE);
        else if (cxr < -38'(Q28_ONE)) qw_q <= -30'(Q28_ONE);
        else                          qw_q <= 30'(cxr);
      end
      default: ;
    endcase
  end

  // ---------------- point pipeline ----------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic last1_q, last2_q, last3_q;
  logic deg1_q, deg2_q, deg3_q;
  logic signed [31:0] px1_q[3], px2_q[3], px3_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: offsets from A and the q*(0,d) products
  logic signed [32:0] d [3];
  logic signed [62:0] pw_q [3];
  logic signed [62:0] pv_q [3][3];

  always_comb begin
    d[0] = 33'(atom_x_i) - 33'(ax_q);
    d[1] = 33'(atom_y_i) - 33'(ay_q);
    d[2] = 33'(atom_z_i) - 33'(az_q);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      pw_q[j] <= 63'(qw_q) * 63'(d[j]);
      for (int i = 0; i < 3; i++) pv_q[i][j] <= 63'(qv_q[i]) * 63'(d[j]);
    end
    px1_q[0] <= atom_x_i;
    px1_q[1] <= atom_y_i;
    px1_q[2] <= atom_z_i;
    last1_q  <= last_atom_i;
    deg1_q   <= degen;
  end

  // stage 2: sums, rounded to Q16.16 units
  logic signed [64:0] rs [4];
  logic signed [36:0] r_q [4];

  always_comb begin
    rs[0] = -(65'(pv_q[0][0]) + 65'(pv_q[1][1]) + 65'(pv_q[2][2]));
    rs[1] = 65'(pw_q[0]) + 65'(pv_q[1][2]) - 65'(pv_q[2][1]);
    rs[2] = 65'(pw_q[1]) - 65'(pv_q[0][2]) + 65'(pv_q[2][0]);
    rs[3] = 65'(pw_q[2]) + 65'(pv_q[0][1]) - 65'(pv_q[1][0]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) r_q[k] <= 37'((rs[k] + 65'sd134217728) >>> 28);
    px2_q   <= px1_q;
    last2_q <= last1_q;
    deg2_q  <= deg1_q;
  end

  // stage 3: r*conj(q) products, floored by 16 bits
  logic signed [50:0] f_q [3][4];

  function automatic logic signed [50:0] fmul(input logic signed [36:0] a,
                                              input logic signed [29:0] b);
    logic signed [66:0] p;
    p = 67'(a) * 67'(b);
    return 51'(p >>> 16);
  endfunction

  always_ff @(posedge clk_i) begin
    f_q[0][0] <= fmul(r_q[0], qv_q[0]);
    f_q[0][1] <= fmul(r_q[1], qw_q);
    f_q[0][2] <= fmul(r_q[2], qv_q[2]);
    f_q[0][3] <= fmul(r_q[3], qv_q[1]);
    f_q[1][0] <= fmul(r_q[0], qv_q[1]);
    f_q[1][1] <= fmul(r_q[1], qv_q[2]);
    f_q[1][2] <= fmul(r_q[2], qw_q);
    f_q[1][3] <= fmul(r_q[3], qv_q[0]);
    f_q[2][0] <= fmul(r_q[0], qv_q[2]);
    f_q[2][1] <= fmul(r_q[1], qv_q[1]);
    f_q[2][2] <= fmul(r_q[2], qv_q[0]);
    f_q[2][3] <= fmul(r_q[3], qw_q);
    px3_q   <= px2_q;
    last3_q <= last2_q;
    deg3_q  <= deg2_q;
  end

  // stage 4: add A, round by 12 bits, saturate
  logic signed [52:0] s [3];
  logic signed [40:0] sr [3];
  logic signed [31:0] sat_v [3];
  logic [2:0]         clip;

  always_comb begin
    s[0] = -53'(f_q[0][0]) + 53'(f_q[0][1]) - 53'(f_q[0][2]) + 53'(f_q[0][3])
           + (53'(ax_q) <<< 12);
    s[1] = -53'(f_q[1][0]) + 53'(f_q[1][1]) + 53'(f_q[1][2]) - 53'(f_q[1][3])
           + (53'(ay_q) <<< 12);
    s[2] = -53'(f_q[2][0]) - 53'(f_q[2][1]) + 53'(f_q[2][2]) + 53'(f_q[2][3])
           + (53'(az_q) <<< 12);
    for (int i = 0; i < 3; i++) begin
      sr[i] = 41'((s[i] + 53'sd2048) >>> 12);
      if (sr[i] > 41'sd2147483647) begin
        sat_v[i] = 32'sh7FFFFFFF;
        clip[i]  = 1'b1;
      end else if (sr[i] < -41'sd2147483648) begin
        sat_v[i] = 32'sh80000000;
        clip[i]  = 1'b1;
      end else begin
        sat_v[i] = 32'(sr[i]);
        clip[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg3_q) begin
      rot_x_o     <= px3_q[0];
      rot_y_o     <= px3_q[1];
      rot_z_o     <= px3_q[2];
      saturated_o <= 1'b0;
    end else begin
      rot_x_o     <= sat_v[0];
      rot_y_o     <= sat_v[1];
      rot_z_o     <= sat_v[2];
      saturated_o <= |clip;
    end
    last_out_o        <= last3_q;
    axis_degenerate_o <= deg3_q;
  end

  assign done_o = v4_q;

`ifndef NO_ASSERTIONS
  // a config write always triggers a quaternion rebuild
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o) else $error("config write did not raise busy");
  // an accepted transaction enters the pipeline
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> v1_q) else $error("accepted point lost");
  // an accepted transaction leaves the point pipeline as a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o) else $error("result latency broken");
  // a degenerate axis passes points without clipping
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && axis_degenerate_o) |-> !saturated_o)
    else $error("degenerate point flagged as saturated");
`endif

endmodule
